// ===== rtl/cop_pkg.sv =====
// ----------------------------------------------------------------------------
// cop_pkg: shared types and constants for the circle outline point generator
// Item, point and tracer state records, function and register codes.
// ----------------------------------------------------------------------------
package cop_pkg;

    localparam logic [10:0] MAX_GRID      = 11'd1024;
    localparam logic [10:0] GRID_RESET    = 11'd64;

    localparam logic        FUNC_START    = 1'b0;
    localparam logic        FUNC_NEXT     = 1'b1;

    localparam logic        REG_GRID_ROWS = 1'b0;
    localparam logic        REG_GRID_COLS = 1'b1;

    localparam logic [2:0]  LAST_OCTANT   = 3'd7;

    typedef struct packed {
        logic       func;
        logic [9:0] ctr_row;
        logic [9:0] ctr_col;
        logic [9:0] radius;
    } cop_item_t;

    typedef struct packed {
        logic signed [11:0] step_x;
        logic signed [11:0] step_y;
        logic signed [13:0] decision;
        logic [2:0]         octant;
        logic [9:0]         centre_row;
        logic [9:0]         centre_col;
        logic               running;
        logic               all_ok;
    } cop_state_t;

    typedef struct packed {
        logic signed [11:0] point_x;
        logic signed [11:0] point_y;
        logic               in_grid;
        logic               last;
        logic               all_in_grid;
    } cop_point_t;

endpackage

// ===== rtl/cop_in_stage.sv =====
// ----------------------------------------------------------------------------
// cop_in_stage: input register
// Captures one input transaction and holds it until the tracer takes it.
// ----------------------------------------------------------------------------
module cop_in_stage
    import cop_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [9:0] s_ctr_row,
    input  logic [9:0] s_ctr_col,
    input  logic [9:0] s_radius,
    output logic       item_valid,
    output cop_item_t  item,
    input  logic       item_take
);

    logic      valid_reg;
    cop_item_t item_reg;

    assign s_ready    = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.func    <= s_func;
            item_reg.ctr_row <= s_ctr_row;
            item_reg.ctr_col <= s_ctr_col;
            item_reg.radius  <= s_radius;
        end
    end

endmodule

// ===== rtl/cop_point_unit.sv =====
// ----------------------------------------------------------------------------
// cop_point_unit: midpoint circle step logic
// Mirrors the current step into one octant point, checks it against the
// grid and works out the tracer state after this point.
// ----------------------------------------------------------------------------
module cop_point_unit
    import cop_pkg::*;
(
    input  cop_item_t   item,
    input  cop_state_t  state_cur,
    input  logic [10:0] grid_rows,
    input  logic [10:0] grid_cols,
    output logic        emit,
    output cop_point_t  point,
    output cop_state_t  state_next
);

    cop_state_t         eff;
    logic signed [11:0] a_ofs;
    logic signed [11:0] b_ofs;
    logic signed [12:0] px_full;
    logic signed [12:0] py_full;
    logic [11:0]        px;
    logic [11:0]        py;
    logic [10:0]        rows_eff;
    logic [10:0]        cols_eff;
    logic               ok;
    logic signed [11:0] x_inc;
    logic signed [11:0] y_dec;
    logic signed [13:0] diff;
    logic signed [13:0] x_inc_w;

    always_comb begin
        eff = state_cur;
        if (item.func == FUNC_START) begin
            eff.centre_row = item.ctr_row;
            eff.centre_col = item.ctr_col;
            eff.step_x     = 12'sd0;
            eff.step_y     = $signed({2'b00, item.radius});
            eff.decision   = 14'sd3 - $signed({3'b000, item.radius, 1'b0});
            eff.octant     = 3'd0;
            eff.all_ok     = 1'b1;
            eff.running    = 1'b1;
        end
    end

    assign emit = (item.func == FUNC_START) || state_cur.running;

    assign a_ofs   = eff.octant[2] ? eff.step_y : eff.step_x;
    assign b_ofs   = eff.octant[2] ? eff.step_x : eff.step_y;
    assign px_full = eff.octant[0]
                   ? $signed({3'b000, eff.centre_row}) - {a_ofs[11], a_ofs}
                   : $signed({3'b000, eff.centre_row}) + {a_ofs[11], a_ofs};
    assign py_full = eff.octant[1]
                   ? $signed({3'b000, eff.centre_col}) - {b_ofs[11], b_ofs}
                   : $signed({3'b000, eff.centre_col}) + {b_ofs[11], b_ofs};
    assign px      = px_full[11:0];
    assign py      = py_full[11:0];

    assign rows_eff = (grid_rows > MAX_GRID) ? MAX_GRID : grid_rows;
    assign cols_eff = (grid_cols > MAX_GRID) ? MAX_GRID : grid_cols;
    assign ok       = !px[11] && !py[11] && (px[10:0] < rows_eff) && (py[10:0] < cols_eff);

    assign x_inc   = eff.step_x + 12'sd1;
    assign y_dec   = eff.step_y - 12'sd1;
    assign x_inc_w = {{2{x_inc[11]}}, x_inc};
    assign diff    = x_inc_w - {{2{y_dec[11]}}, y_dec};

    always_comb begin
        state_next        = eff;
        state_next.all_ok = eff.all_ok && ok;
        point.last        = 1'b0;
        if (eff.octant == LAST_OCTANT) begin
            state_next.octant = 3'd0;
            if (eff.step_y >= eff.step_x) begin
                state_next.step_x = x_inc;
                if (eff.decision > 14'sd0) begin
                    state_next.step_y   = y_dec;
                    state_next.decision = eff.decision + (diff <<< 2) + 14'sd10;
                end else begin
                    state_next.decision = eff.decision + (x_inc_w <<< 2) + 14'sd6;
                end
            end else begin
                state_next.running = 1'b0;
                point.last         = 1'b1;
            end
        end else begin
            state_next.octant = eff.octant + 3'd1;
        end
        point.point_x     = px;
        point.point_y     = py;
        point.in_grid     = ok;
        point.all_in_grid = eff.all_ok && ok;
    end

endmodule

// ===== rtl/circle_outline_point_generator.sv =====
// Path: an accepted input transaction is held in the input register, then its
// point is held in the result register that drives m_*.
// Throughput: one transaction per cycle while m_* is not stalled; a start or next
// item each yields one point, a next item while idle yields none.
// Rate is set by the single tracer state register updated once per point.
// Reset: tracer idle, grid_rows and grid_cols 64, all pipeline stages empty.
// ----------------------------------------------------------------------------
// circle_outline_point_generator: midpoint circle outline rasterizer
// Emits the eight mirrored octant points of each step with grid checks.
// ----------------------------------------------------------------------------
module circle_outline_point_generator
    import cop_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [9:0]  s_ctr_row,
    input  logic [9:0]  s_ctr_col,
    input  logic [9:0]  s_radius,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_point_x,
    output logic [11:0] m_point_y,
    output logic        m_in_grid,
    output logic        m_last,
    output logic        m_all_in_grid
);

    logic        item_valid;
    cop_item_t   item;
    logic        item_take;
    logic        out_free;
    logic        emit;
    cop_point_t  point;
    cop_state_t  state_next;
    cop_state_t  state_reg;
    cop_point_t  point_reg;
    logic        m_valid_reg;
    logic [10:0] grid_rows_reg;
    logic [10:0] grid_cols_reg;

    cop_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_ctr_row  (s_ctr_row),
        .s_ctr_col  (s_ctr_col),
        .s_radius   (s_radius),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    cop_point_unit u_point_unit (
        .item       (item),
        .state_cur  (state_reg),
        .grid_rows  (grid_rows_reg),
        .grid_cols  (grid_cols_reg),
        .emit       (emit),
        .point      (point),
        .state_next (state_next)
    );

    assign out_free  = !m_valid_reg || m_ready;
    assign item_take = item_valid && out_free;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= GRID_RESET;
            grid_cols_reg <= GRID_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_data;
                REG_GRID_COLS: grid_cols_reg <= cfg_data;
                default:       grid_rows_reg <= grid_rows_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            state_reg   <= '{step_x: 12'sd0, step_y: 12'sd0, decision: 14'sd0,
                             octant: 3'd0, centre_row: 10'd0, centre_col: 10'd0,
                             running: 1'b0, all_ok: 1'b1};
        end else begin
            if (out_free) begin
                m_valid_reg <= item_take && emit;
            end
            if (item_take && emit) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (item_take && emit) begin
            point_reg <= point;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_point_x     = point_reg.point_x;
    assign m_point_y     = point_reg.point_y;
    assign m_in_grid     = point_reg.in_grid;
    assign m_last        = point_reg.last;
    assign m_all_in_grid = point_reg.all_in_grid;

`ifndef SYNTHESIS
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> !state_reg.running)
        else $error("last point pending while tracer still running");

    a_all_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_grid |-> !m_all_in_grid)
        else $error("all_in_grid set on an out-of-grid point");

    a_octant_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.octant != 3'd0 |-> state_reg.running)
        else $error("octant advanced while tracer idle");
`endif

endmodule
